@@ sv/rsl_pkg.sv @@
// Shared types and constants of the radial spotlight luminance block.
package rsl_pkg;

   // Field widths.
   localparam int COORD_BITS     = 12;
   localparam int LUMA_FRAC_BITS = 15;
   localparam int LUMA_W         = LUMA_FRAC_BITS + 1;
   localparam int CENTER_BITS    = 14;

   // Distance datapath widths.
   localparam int DX_W  = ((CENTER_BITS > COORD_BITS) ? CENTER_BITS : COORD_BITS + 1) + 1;
   localparam int MAG_W = DX_W - 1;
   localparam int SQ_W  = 2 * MAG_W;
   localparam int SUM_W = SQ_W + 1;

   // Square root in Q8.8: the radicand is the squared distance shifted up by 16.
   localparam int Q_FRAC = 8;
   localparam int ROOT_W = 16;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;

   localparam logic [SUM_W-1:0]  RADIUS_SQ  = SUM_W'(25600);
   localparam logic [ROOT_W-1:0] FULL_SCALE = ROOT_W'(51200);
   localparam logic [ROOT_W-1:0] FAR_DIST   = ROOT_W'(40960);
   localparam logic [LUMA_W-1:0] LUMA_ONE   = {1'b1, {LUMA_FRAC_BITS{1'b0}}};

   // Division by 51200 = 25 * 2^11: a shift, then a reciprocal multiply by 1/25.
   localparam int DIV_SHIFT   = 11;
   localparam int DIV_ODD     = 25;
   localparam int PROD_W      = LUMA_W + ROOT_W;
   localparam int X_W         = PROD_W - DIV_SHIFT;
   localparam int RECIP_SHIFT = LUMA_FRAC_BITS + 10;
   localparam int RECIP_W     = RECIP_SHIFT - 4;
   localparam int RPROD_W     = X_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_MULT =
      RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_ODD);

   // Pipeline depth from request to result.
   localparam int PIPE_LATENCY = 3 + ROOT_W + 4;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_COL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_ROW = 1'b1;

   // One slot of the square-root chain.
   typedef struct packed {
      logic              valid;
      logic              far;
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [LUMA_W-1:0] luma;
   } lane_type;

endpackage

@@ sv/radial_spotlight_luminance.sv @@
// Top level of the radial spotlight luminance block.
//
// Each request brings one pixel's column, row and luminance (unsigned Q1.15).
// The block scales the luminance by 1 - 0.005 * distance from the configured
// centre, or by 0.2 beyond a radius of 160, truncating the result.
// A request is taken at a clock edge where start is high and busy is low;
// busy is high only while reset is asserted. Requests may come in every
// cycle and are handled in order, one result per request.
// The result appears on rsp_luma_out with rsp_valid high for exactly one
// cycle, after three distance stages, a chain of 16
// square-root cells that each settle one root bit, and four scaling stages.
// The receiver has no back-pressure; every result must be taken as shown.
// Throughput is one pixel per clock.
// The centre column and row are written through the csr_ port (index 0 and
// 1), which takes a write in any cycle outside reset; write them only while
// no request is in flight. Reset empties the pipeline and sets the centre
// to zero.
module radial_spotlight_luminance (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [rsl_pkg::COORD_BITS-1:0]  req_pixel_col,
   input  logic [rsl_pkg::COORD_BITS-1:0]  req_pixel_row,
   input  logic [rsl_pkg::LUMA_W-1:0]      req_luma_in,
   output logic                            rsp_valid,
   output logic [rsl_pkg::LUMA_W-1:0]      rsp_luma_out,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rsl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rsl_pkg::CENTER_BITS-1:0] csr_wdata
);
   import rsl_pkg::*;

   logic [CENTER_BITS-1:0] center_col_ff;
   logic [CENTER_BITS-1:0] center_row_ff;
   logic                   req_accept;
   logic [LUMA_W-1:0]      luma_sat;

   logic                   s1_valid_ff;
   logic [DX_W-1:0]        s1_dx_ff;
   logic [DX_W-1:0]        s1_dy_ff;
   logic [DX_W-1:0]        s1_dx_in;
   logic [DX_W-1:0]        s1_dy_in;
   logic [LUMA_W-1:0]      s1_luma_ff;

   logic                   s2_valid_ff;
   logic [MAG_W-1:0]       s2_magx_in;
   logic [MAG_W-1:0]       s2_magy_in;
   logic [SQ_W-1:0]        s2_sqx_ff;
   logic [SQ_W-1:0]        s2_sqy_ff;
   logic [LUMA_W-1:0]      s2_luma_ff;

   logic [SUM_W-1:0]       s3_sum;
   lane_type               s3_lane_in;
   lane_type               s3_lane_ff;

   lane_type               lanes [ROOT_W+1];

   assign busy       = reset;
   assign csr_ready  = ~reset;
   assign req_accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff <= '0;
         center_row_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CENTER_COL: center_col_ff <= csr_wdata;
            REG_CENTER_ROW: center_row_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Luminance above 1.0 is clamped so the result never exceeds 1.0.
   assign luma_sat = (req_luma_in > LUMA_ONE) ? LUMA_ONE : req_luma_in;

   assign s1_dx_in =
      {{(DX_W-CENTER_BITS){center_col_ff[CENTER_BITS-1]}}, center_col_ff}
      - {{(DX_W-COORD_BITS){1'b0}}, req_pixel_col};
   assign s1_dy_in =
      {{(DX_W-CENTER_BITS){center_row_ff[CENTER_BITS-1]}}, center_row_ff}
      - {{(DX_W-COORD_BITS){1'b0}}, req_pixel_row};

   assign s2_magx_in = MAG_W'(s1_dx_ff[DX_W-1] ? -s1_dx_ff : s1_dx_ff);
   assign s2_magy_in = MAG_W'(s1_dy_ff[DX_W-1] ? -s1_dy_ff : s1_dy_ff);

   assign s3_sum = {1'b0, s2_sqx_ff} + {1'b0, s2_sqy_ff};

   always_comb begin
      s3_lane_in.valid = s2_valid_ff;
      s3_lane_in.far   = (s3_sum > RADIUS_SQ);
      s3_lane_in.rad   = s3_lane_in.far ? '0
                         : {s3_sum[RAD_W-2*Q_FRAC-1:0], {(2*Q_FRAC){1'b0}}};
      s3_lane_in.rem   = '0;
      s3_lane_in.root  = '0;
      s3_lane_in.luma  = s2_luma_ff;
   end

   always_ff @(posedge clock) begin
      s1_dx_ff   <= s1_dx_in;
      s1_dy_ff   <= s1_dy_in;
      s1_luma_ff <= luma_sat;
      s2_sqx_ff  <= {{MAG_W{1'b0}}, s2_magx_in} * {{MAG_W{1'b0}}, s2_magx_in};
      s2_sqy_ff  <= {{MAG_W{1'b0}}, s2_magy_in} * {{MAG_W{1'b0}}, s2_magy_in};
      s2_luma_ff <= s1_luma_ff;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_lane_ff  <= '0;
      end else begin
         s1_valid_ff <= req_accept;
         s2_valid_ff <= s1_valid_ff;
         s3_lane_ff  <= s3_lane_in;
      end
   end

   assign lanes[0] = s3_lane_ff;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
      rsl_sqrt_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .lane_i (lanes[i]),
         .lane_o (lanes[i+1])
      );
   end

   rsl_atten u_atten (
      .clock       (clock),
      .reset       (reset),
      .lane_i      (lanes[ROOT_W]),
      .rsp_valid_o (rsp_valid),
      .rsp_luma_o  (rsp_luma_out)
   );

   // Every accepted request yields exactly one result after the fixed latency.
   // History from before the first clock edges is unknown and counts as idle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == ($past(req_accept, PIPE_LATENCY) === 1'b1))
      else $error("result strobe does not match accepted requests");

   // Attenuation never raises the clamped luminance.
   a_no_gain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_luma_out <= $past(luma_sat, PIPE_LATENCY)))
      else $error("result luminance above its input");

   // Inside the radius the root cannot pass 160.0 in Q8.8.
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (lanes[ROOT_W].valid && !lanes[ROOT_W].far) |-> (lanes[ROOT_W].root <= FAR_DIST))
      else $error("square root beyond the spotlight radius");

endmodule

@@ sv/rsl_sqrt_cell.sv @@
// One cell of the square-root chain: settles one root bit per cycle.
module rsl_sqrt_cell (
   input  logic            clock,
   input  logic            reset,
   input  rsl_pkg::lane_type lane_i,
   output rsl_pkg::lane_type lane_o
);
   import rsl_pkg::*;

   lane_type          lane_in;
   lane_type          lane_ff;
   logic [REM_W-1:0]  cur;
   logic [REM_W-1:0]  trial;
   logic              fits;

   // Bring down the next two radicand bits and try the root with a one appended.
   assign cur   = {lane_i.rem[REM_W-3:0], lane_i.rad[RAD_W-1 -: 2]};
   assign trial = {lane_i.root, 2'b01};
   assign fits  = (cur >= trial);

   always_comb begin
      lane_in      = lane_i;
      lane_in.rad  = {lane_i.rad[RAD_W-3:0], 2'b00};
      lane_in.rem  = fits ? (cur - trial) : cur;
      lane_in.root = {lane_i.root[ROOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
      end else begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule

@@ sv/rsl_atten.sv @@
// Attenuation stages: factor, luminance product and exact division by 51200.
module rsl_atten (
   input  logic                       clock,
   input  logic                       reset,
   input  rsl_pkg::lane_type          lane_i,
   output logic                       rsp_valid_o,
   output logic [rsl_pkg::LUMA_W-1:0] rsp_luma_o
);
   import rsl_pkg::*;

   logic                s4_valid_ff;
   logic [ROOT_W-1:0]   s4_factor_ff;
   logic [ROOT_W-1:0]   s4_factor_in;
   logic [LUMA_W-1:0]   s4_luma_ff;
   logic                s5_valid_ff;
   logic [PROD_W-1:0]   s5_prod_ff;
   logic                s6_valid_ff;
   logic [X_W-1:0]      s6_x_ff;
   logic [LUMA_W-1:0]   s6_q_ff;
   logic [X_W-1:0]      s6_x_in;
   logic [RPROD_W-1:0]  s6_rprod_in;
   logic                s7_valid_ff;
   logic [LUMA_W-1:0]   s7_q_ff;
   logic [LUMA_W-1:0]   s7_q_in;
   logic [X_W-1:0]      s7_rem;

   // Outside the radius the distance is held at 160.0, giving a factor of 0.2.
   assign s4_factor_in = FULL_SCALE - (lane_i.far ? FAR_DIST : lane_i.root);

   // The reciprocal of 25 is rounded down, so the estimate is low by at most one.
   assign s6_x_in     = s5_prod_ff[PROD_W-1:DIV_SHIFT];
   assign s6_rprod_in = {{RECIP_W{1'b0}}, s6_x_in} * {{X_W{1'b0}}, RECIP_MULT};

   assign s7_rem  = s6_x_ff - X_W'({{(X_W-LUMA_W){1'b0}}, s6_q_ff} * X_W'(DIV_ODD));
   assign s7_q_in = (s7_rem >= X_W'(DIV_ODD)) ? (s6_q_ff + LUMA_W'(1)) : s6_q_ff;

   always_ff @(posedge clock) begin
      s4_factor_ff <= s4_factor_in;
      s4_luma_ff   <= lane_i.luma;
      s5_prod_ff   <= {{ROOT_W{1'b0}}, s4_luma_ff} * {{LUMA_W{1'b0}}, s4_factor_ff};
      s6_x_ff      <= s6_x_in;
      s6_q_ff      <= s6_rprod_in[RECIP_SHIFT +: LUMA_W];
      s7_q_ff      <= s7_q_in;
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= lane_i.valid;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   assign rsp_valid_o = s7_valid_ff;
   assign rsp_luma_o  = s7_q_ff;

endmodule

@@ dv/tb_radial_spotlight_luminance.sv @@
// Self-checking testbench for the radial spotlight luminance block.
module tb_radial_spotlight_luminance;
   timeunit 1ns;
   timeprecision 1ps;

   import rsl_pkg::*;

   localparam longint SPOT_RADIUS_SQ = 25600;
   localparam longint SCALE_Q88      = 51200;
   localparam longint FAR_Q88        = 40960;
   localparam longint LUMA_FULL      = longint'(1) << LUMA_FRAC_BITS;
   localparam int     COORD_MAX      = (1 << COORD_BITS) - 1;
   localparam int     CENTER_MIN     = -(1 << (CENTER_BITS - 1));
   localparam int     CENTER_MAX     = (1 << (CENTER_BITS - 1)) - 1;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [COORD_BITS-1:0]  req_pixel_col;
   logic [COORD_BITS-1:0]  req_pixel_row;
   logic [LUMA_W-1:0]      req_luma_in;
   logic                   rsp_valid;
   logic [LUMA_W-1:0]      rsp_luma_out;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CENTER_BITS-1:0] csr_wdata;

   radial_spotlight_luminance DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_pixel_col(req_pixel_col),
      .req_pixel_row(req_pixel_row),
      .req_luma_in  (req_luma_in),
      .rsp_valid    (rsp_valid),
      .rsp_luma_out (rsp_luma_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Spotlight centre as the block should hold it.
   int spot_col;
   int spot_row;

   logic [LUMA_W-1:0] luma_expected[$];
   int idle_pct;
   int pixels_sent;
   int results_checked;
   int centers_written;
   int mismatches;

   function automatic longint floor_sqrt(longint v);
      longint root;
      longint trial;
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= v)
            root = trial;
      end
      return root;
   endfunction

   function automatic logic [LUMA_W-1:0] attenuate_luma(logic [COORD_BITS-1:0] col,
                                                         logic [COORD_BITS-1:0] row,
                                                         logic [LUMA_W-1:0] luma);
      longint level;
      longint dx;
      longint dy;
      longint dist_sq;
      longint dist_q88;
      level = luma;
      if (level > LUMA_FULL)
         level = LUMA_FULL;
      dx = longint'(spot_col) - longint'({1'b0, col});
      dy = longint'(spot_row) - longint'({1'b0, row});
      dist_sq = dx * dx + dy * dy;
      // Beyond the radius the factor is a flat 0.2, the same as a distance of 160.
      if (dist_sq > SPOT_RADIUS_SQ)
         dist_q88 = FAR_Q88;
      else
         dist_q88 = floor_sqrt(dist_sq << 16);
      return LUMA_W'((level * (SCALE_Q88 - dist_q88)) / SCALE_Q88);
   endfunction

   // A pixel coordinate within 200 of a centre, clamped to the image.
   function automatic logic [COORD_BITS-1:0] near_coord(int c);
      int v;
      v = c + int'($urandom_range(0, 400)) - 200;
      if (v < 0)
         v = 0;
      if (v > COORD_MAX)
         v = COORD_MAX;
      return COORD_BITS'(v);
   endfunction

   task automatic send_pixel(int col, int row, int luma);
      req_pixel_col <= COORD_BITS'(col);
      req_pixel_row <= COORD_BITS'(row);
      req_luma_in   <= LUMA_W'(luma);
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      luma_expected.push_back(attenuate_luma(COORD_BITS'(col), COORD_BITS'(row),
                                             LUMA_W'(luma)));
      pixels_sent++;
      // Each following cycle stays idle with the phase's probability.
      while (int'($urandom_range(0, 99)) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Hold the sender off until every outstanding request has its result.
   task automatic drain_pipeline();
      start <= 1'b0;
      do @(posedge clock); while (luma_expected.size() != 0);
   endtask

   task automatic set_center(int col, int row);
      csr_valid <= 1'b1;
      csr_index <= REG_CENTER_COL;
      csr_wdata <= CENTER_BITS'(col);
      do @(posedge clock); while (!csr_ready);
      spot_col = col;
      csr_index <= REG_CENTER_ROW;
      csr_wdata <= CENTER_BITS'(row);
      do @(posedge clock); while (!csr_ready);
      spot_row = row;
      csr_valid <= 1'b0;
      centers_written++;
   endtask

   // Centre at reset: luminance extremes, saturation and the radius boundary.
   task automatic test_reset_center();
      send_pixel(0, 0, 0);
      send_pixel(0, 0, 32768);
      send_pixel(0, 0, 32769);
      send_pixel(0, 0, 65535);
      send_pixel(0, 0, 32767);
      send_pixel(1, 0, 32768);
      send_pixel(0, 1, 12345);
      send_pixel(160, 0, 32768);
      send_pixel(96, 128, 32768);
      send_pixel(160, 1, 32768);
      send_pixel(113, 113, 30000);
      send_pixel(4095, 0, 1);
      send_pixel(0, 4095, 32767);
      send_pixel(4095, 4095, 65535);
   endtask

   // Centres at the register limits and at an image corner, and one inside the image at the radius.
   task automatic test_center_extremes();
      int ext_col[5] = '{CENTER_MIN, CENTER_MAX, CENTER_MIN, CENTER_MAX, 4095};
      int ext_row[5] = '{CENTER_MIN, CENTER_MAX, CENTER_MAX, CENTER_MIN, 0};
      for (int i = 0; i < 5; i++) begin
         drain_pipeline();
         set_center(ext_col[i], ext_row[i]);
         send_pixel(0, 0, $urandom_range(0, 32768));
         send_pixel(COORD_MAX, COORD_MAX, 32768);
         send_pixel(COORD_MAX, 0, $urandom_range(0, 65535));
      end
      drain_pipeline();
      set_center(2048, 2048);
      send_pixel(2048, 2048, 32768);
      send_pixel(2208, 2048, 32768);
      send_pixel(2048, 1888, 32768);
      send_pixel(1952, 2176, 32768);
      send_pixel(2209, 2048, 32768);
   endtask

   // Random pixels, mostly near the centre so that the square-root path is hit.
   task automatic test_random_phases();
      int phase_idle[3] = '{0, 88, 25};
      int col;
      int row;
      int luma;
      int pick;
      for (int seg = 0; seg < 9; seg++) begin
         drain_pipeline();
         idle_pct = phase_idle[seg % 3];
         pick = $urandom_range(0, 9);
         if (pick < 7)
            set_center($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
         else
            set_center(int'($urandom_range(0, CENTER_MAX - CENTER_MIN)) + CENTER_MIN,
                       int'($urandom_range(0, CENTER_MAX - CENTER_MIN)) + CENTER_MIN);
         for (int n = 0; n < 150; n++) begin
            if ($urandom_range(0, 99) < 85) begin
               col = int'(near_coord(spot_col));
               row = int'(near_coord(spot_row));
            end else begin
               col = $urandom_range(0, COORD_MAX);
               row = $urandom_range(0, COORD_MAX);
            end
            pick = $urandom_range(0, 9);
            if (pick < 7)
               luma = $urandom_range(0, 32768);
            else if (pick == 7)
               luma = ($urandom_range(0, 1) == 1) ? 32768 : 0;
            else
               luma = $urandom_range(0, 65535);
            send_pixel(col, row, luma);
            // Now and then let the pipeline run dry mid-phase.
            if ($urandom_range(0, 199) == 0)
               drain_pipeline();
         end
      end
   endtask

   always @(posedge clock) begin : check_luma
      logic [LUMA_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (luma_expected.size() == 0) begin
            $error("luma_out: unexpected result %0d with nothing expected", rsp_luma_out);
            mismatches++;
         end else begin
            want = luma_expected.pop_front();
            results_checked++;
            if (rsp_luma_out !== want) begin
               $error("luma_out mismatch: expected %0d, actual %0d", want, rsp_luma_out);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      spot_col = 0;
      spot_row = 0;
      idle_pct = 0;
      pixels_sent = 0;
      results_checked = 0;
      centers_written = 0;
      mismatches = 0;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_pixel_col <= '0;
      req_pixel_row <= '0;
      req_luma_in   <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= REG_CENTER_COL;
      csr_wdata     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_center();
      test_center_extremes();
      test_random_phases();

      drain_pipeline();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (luma_expected.size() != 0) begin
         $error("luma_out: %0d expected results never arrived", luma_expected.size());
         mismatches++;
      end
      $display("Sent %0d pixels over %0d centre settings, %0d results checked.",
               pixels_sent, centers_written, results_checked);
      $display("Covered saturation, the radius boundary and centres at the register limits.");
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
sv/rsl_pkg.sv
sv/rsl_sqrt_cell.sv
sv/rsl_atten.sv
sv/radial_spotlight_luminance.sv
dv/tb_radial_spotlight_luminance.sv
